// ----- sv/fmi_pkg.sv -----
// Shared constants for the Fermat modular inverse block.
package fmi_pkg;

	localparam int unsigned W       = 30;
	localparam int unsigned CNT_W   = $clog2(W);
	localparam int unsigned TDATA_W = ((W + 7) / 8) * 8;
	localparam int unsigned SUM_W   = W + 2;

	localparam logic [W-1:0]     MODULUS   = W'(1000000007);
	localparam logic [W-1:0]     EXPONENT  = W'(1000000005);
	localparam logic [SUM_W-1:0] MOD_X1    = SUM_W'(1000000007);
	localparam logic [SUM_W-1:0] MOD_X2    = SUM_W'(2000000014);

	// handshake between the sequencer and a multiplier
	typedef struct packed {
		logic start;
	} mul_req_t;

	typedef struct packed {
		logic done;
	} mul_rsp_t;

endpackage

// ----- sv/fmi_modmul.sv -----
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module fmi_modmul
	import fmi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  mul_req_t     req,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output mul_rsp_t     rsp,
	output logic [W-1:0] product
);

	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [W-1:0]     r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] addend;
	logic [SUM_W-1:0] red;

	// r < M, so 2r + a < 3M: at most one subtraction of M or 2M
	always_comb begin
		addend = b_q[W-1] ? {2'b00, a_q} : '0;
		sum    = {1'b0, r_q, 1'b0} + addend;
		if (sum >= MOD_X2) begin
			red = sum - MOD_X2;
		end else if (sum >= MOD_X1) begin
			red = sum - MOD_X1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= red[W-1:0];
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign product  = r_q;

endmodule

// ----- sv/fermat_modular_inverse.sv -----
// Modular inverse modulo 1000000007 by right-to-left square-and-multiply.
// The 30 exponent bits are handled one at a time by the bit-serial multipliers
// (square and multiply run side by side on two of them). The next input is taken
// once the result has been taken, so only one item is in flight at a time.
// Reset (arst_n, asynchronous, active low) returns the sequencer to idle.
module fermat_modular_inverse
	import fmi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [29:0] value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata    // [29:0] inverse
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] bit_q;
	logic [W-1:0]     exp_q;
	logic [W-1:0]     acc_q;
	logic [W-1:0]     base_q;

	logic [W-1:0] in_val;
	logic [W-1:0] in_red;
	mul_req_t     req;
	mul_rsp_t     rsp_mul;
	mul_rsp_t     rsp_sq;
	logic [W-1:0] p_mul;
	logic [W-1:0] p_sq;

	assign in_val    = s_tdata[W-1:0];
	// inputs at or above the modulus fold back with one subtraction
	assign in_red    = (in_val >= MODULUS) ? (in_val - MODULUS) : in_val;
	assign req.start = (state_q == ST_START);

	fmi_modmul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.a       (acc_q),
		.b       (base_q),
		.rsp     (rsp_mul),
		.product (p_mul)
	);

	fmi_modmul u_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.a       (base_q),
		.b       (base_q),
		.rsp     (rsp_sq),
		.product (p_sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_START;
						bit_q   <= CNT_W'(W - 1);
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (rsp_sq.done) begin
						if (bit_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							bit_q   <= bit_q - CNT_W'(1);
							state_q <= ST_START;
						end
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			acc_q  <= W'(1);
			base_q <= in_red;
			exp_q  <= EXPONENT;
		end else if (state_q == ST_WAIT && rsp_sq.done) begin
			if (exp_q[0]) begin
				acc_q <= p_mul;
			end
			base_q <= p_sq;
			exp_q  <= {1'b0, exp_q[W-1:1]};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {{(TDATA_W - W){1'b0}}, acc_q};

	// both multipliers are started together and must finish together
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_sq.done == rsp_mul.done)
		else $error("multiplier completion out of step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_START))
		else $error("accepted transaction did not start a multiply");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT || state_q == ST_OUT) |->
		(acc_q < MODULUS && base_q < MODULUS))
		else $error("residue escaped the modulus");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while result pending");

endmodule

// ----- test/fermat_modular_inverse_checker.sv -----
// Stream checker for the modular inverse block: predicts each inverse and compares the output.
module fermat_modular_inverse_checker
	import fmi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [29:0] value
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,   // [29:0] inverse
	output int                 mismatch_count,
	output int                 awaited_count,
	output int                 checked_count
);

	typedef struct {
		logic [W-1:0] residue;
		logic [W-1:0] inverse;
	} inverse_entry_t;

	inverse_entry_t expected_inverses [$];
	int mismatches = 0;
	int checked = 0;
	int awaited = 0;

	assign mismatch_count = mismatches;
	assign checked_count  = checked;
	assign awaited_count  = awaited;

	// residue^(p-2) mod p, right-to-left over the exponent bits
	function automatic logic [W-1:0] fermat_power(input logic [W-1:0] residue);
		longint unsigned acc;
		longint unsigned base;
		acc  = 1;
		base = residue;
		for (int i = 0; i < W; i++) begin
			if (EXPONENT[i])
				acc = (acc * base) % MODULUS;
			base = (base * base) % MODULUS;
		end
		return acc[W-1:0];
	endfunction

	always @(posedge clk) begin
		inverse_entry_t entry;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				entry.residue = s_tdata[W-1:0];
				entry.inverse = fermat_power(s_tdata[W-1:0]);
				expected_inverses.insert(expected_inverses.size(), entry);
			end
			if (m_tvalid && m_tready) begin
				if (expected_inverses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected inverse transaction: %0d",
							m_tdata[W-1:0]);
				end else begin
					entry = expected_inverses.pop_front();
					checked++;
					if (m_tdata[W-1:0] !== entry.inverse) begin
						mismatches++;
						if (mismatches <= 10)
							$display("inverse of %0d: expected %0d, got %0d",
								entry.residue, entry.inverse, m_tdata[W-1:0]);
					end
				end
			end
			awaited = expected_inverses.size();
		end
	end

endmodule

// ----- test/fermat_modular_inverse_test.sv -----
// Testbench top for the modular inverse block: stimulus, pacing and verdict.
module fermat_modular_inverse_test;
	import fmi_pkg::*;

	localparam int RANDOM_PER_PHASE = 610;
	localparam int DRAIN_CYCLES     = 1000;
	localparam longint CYCLE_LIMIT  = 16_000_000;
	localparam int NUM_CORNERS      = 20;

	// zero, unity, halves, values either side of the modulus, bit patterns, all ones
	localparam logic [W-1:0] CORNER_RESIDUES [NUM_CORNERS] = '{
		30'd0, 30'd1, 30'd2, 30'd3, 30'd7, 30'd31623, 30'd65536, 30'd123456789,
		30'd500000003, 30'd500000004, 30'd999999999, 30'd1000000005,
		30'd1000000006, 30'd1000000007, 30'd1000000008, 30'h15555555,
		30'h2AAAAAAA, 30'h20000000, 30'h3FFFFFFE, 30'h3FFFFFFF
	};

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;

	int send_idle_pct = 35;
	int recv_idle_pct = 88;
	int sent_count    = 0;
	longint cycle_count = 0;
	int mismatch_count;
	int awaited_count;
	int checked_count;

	fermat_modular_inverse dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fermat_modular_inverse_checker inverse_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.awaited_count  (awaited_count),
		.checked_count  (checked_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cycle limit hit, %0d inverses outstanding", awaited_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// called and returns at a falling edge; valid stays high into the next transaction
	// unless a gap is drawn
	task automatic push_residue(input logic [W-1:0] residue);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		// occasional long pause so gaps land anywhere in the exponentiation
		if (send_idle_pct != 0 && $urandom_range(0, 7) == 0)
			gap += $urandom_range(1, 1000);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(residue);
		do @(posedge clk); while (!s_tready);
		sent_count++;
		@(negedge clk);
	endtask

	initial begin
		int unsigned pick;
		logic [W-1:0] residue;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (CORNER_RESIDUES[i])
			push_residue(CORNER_RESIDUES[i]);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 35; recv_idle_pct = 88; end
				1: begin send_idle_pct = 88; recv_idle_pct = 35; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					residue = W'($urandom_range(1, MODULUS - 1));
				else if (pick < 80)
					residue = W'($urandom_range(MODULUS, 30'h3FFFFFFF));
				else if (pick < 88)
					residue = W'($urandom_range(0, 255));
				else if (pick < 96)
					residue = MODULUS - 1 - W'($urandom_range(0, 255));
				else
					residue = '0;
				push_residue(residue);
			end
		end
		s_tvalid <= 1'b0;

		while (awaited_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d residues sent (corners, in-range, above-modulus, zero), %0d inverses checked",
			sent_count, checked_count);
		$display("pacing: sender/receiver idle 35/88, then 88/35, then back-to-back");
		if (mismatch_count == 0 && awaited_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
